// ----- rtl/core/llfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and byte tables for the laser link setup and frame decode core.
package llfd_pkg;

    // Job queue depth between front and back
    localparam int JobDepth = 4;
    localparam int JobPtrW  = $clog2(JobDepth);

    // Input opcodes
    typedef enum logic [2:0] {
        OP_RESTART = 3'd0,
        OP_TICK    = 3'd1,
        OP_TX_DONE = 3'd2,
        OP_RX_BYTE = 3'd3,
        OP_TRIGGER = 3'd4
    } t_opcode;

    // Result kinds on the output channel
    typedef enum logic [1:0] {
        RK_TX_BYTE = 2'd0,
        RK_BAUD    = 2'd1,
        RK_READING = 2'd2,
        RK_TRIGGER = 2'd3
    } t_result_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BAUD_ADDR   = 3'd0,
        CFG_IL_LO_ADDR  = 3'd1,
        CFG_IL_HI_ADDR  = 3'd2,
        CFG_SP_LO_ADDR  = 3'd3,
        CFG_SP_HI_ADDR  = 3'd4,
        CFG_MODE_ADDR   = 3'd5,
        CFG_FIRST_WAIT  = 3'd6,
        CFG_BAUD_WAIT   = 3'd7
    } t_cfg_index;

    // Jobs handed from front to back
    typedef enum logic [2:0] {
        JOB_WRITE   = 3'd0,
        JOB_BAUD    = 3'd1,
        JOB_CMD     = 3'd2,
        JOB_READING = 3'd3,
        JOB_TRIGGER = 3'd4
    } t_job_kind;

    // Link protocol bytes
    localparam logic [7:0] WR_HEAD0     = 8'h01;
    localparam logic [7:0] WR_HEAD1     = 8'h83;
    localparam logic [7:0] NIB_FLAG     = 8'h80;
    localparam logic [7:0] NIB_MASK     = 8'h0f;
    localparam logic [7:0] TAG_MASK     = 8'h30;
    localparam logic [7:0] BAUD_VALUE   = 8'd48;
    localparam logic [7:0] IL_LO_VALUE  = 8'h80;
    localparam logic [7:0] SP_LO_VALUE  = 8'h01;
    localparam logic [7:0] SP_HI_VALUE  = 8'h00;
    localparam logic [7:0] IL_HI_VALUE  = 8'h02;
    localparam logic [7:0] MODE_VALUE   = 8'h01;
    localparam logic [7:0] STREAM_BYTE0 = 8'h00;
    localparam logic [7:0] STREAM_BYTE1 = 8'h87;

    typedef struct packed {
        logic [7:0] baud_addr;
        logic [7:0] il_lo_addr;
        logic [7:0] il_hi_addr;
        logic [7:0] sp_lo_addr;
        logic [7:0] sp_hi_addr;
        logic [7:0] mode_addr;
        logic [6:0] first_wait;
        logic [6:0] baud_wait;
    } t_cfg;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  addr;
        logic [7:0]  val;
        logic [15:0] reading;
        logic [1:0]  count;
        logic        ready;
    } t_job;

    // Number of results a job expands to, minus one
    function automatic logic [2:0] job_last_idx(input t_job_kind kind);
        case (kind)
            JOB_WRITE: job_last_idx = 3'd5;
            JOB_CMD:   job_last_idx = 3'd1;
            default:   job_last_idx = 3'd0;
        endcase
    endfunction

    function automatic t_result_kind job_result_kind(input t_job_kind kind);
        case (kind)
            JOB_BAUD:    job_result_kind = RK_BAUD;
            JOB_READING: job_result_kind = RK_READING;
            JOB_TRIGGER: job_result_kind = RK_TRIGGER;
            default:     job_result_kind = RK_TX_BYTE;
        endcase
    endfunction

    // Byte sent at position idx of a job; zero for non-transmit results
    function automatic logic [7:0] job_tx_byte(input t_job_kind kind, input logic [7:0] addr,
                                              input logic [7:0] val, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (kind == JOB_WRITE) begin
            case (idx)
                3'd0:    b = WR_HEAD0;
                3'd1:    b = WR_HEAD1;
                3'd2:    b = NIB_FLAG | (addr & NIB_MASK);
                3'd3:    b = NIB_FLAG | {4'h0, addr[7:4]};
                3'd4:    b = NIB_FLAG | (val & NIB_MASK);
                3'd5:    b = NIB_FLAG | {4'h0, val[7:4]};
                default: b = 8'h00;
            endcase
        end else if (kind == JOB_CMD) begin
            b = (idx == 3'd0) ? STREAM_BYTE0 : STREAM_BYTE1;
        end
        return b;
    endfunction

endpackage

// ----- rtl/core/llfd_front.sv -----
`timescale 1ns / 1ps
// Front end: setup sequencer, tick counter and frame gathering; issues jobs.
module llfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_opcode,
    input  logic [7:0]          i_data_byte,
    input  llfd_pkg::t_cfg      i_cfg,
    output logic                o_job_push,
    output llfd_pkg::t_job      o_job
);

    // Setup sequence states
    typedef enum logic [9:0] {
        ST_IDLE       = 10'b0000000001,
        ST_WAIT_FIRST = 10'b0000000010,
        ST_WAIT_BAUD  = 10'b0000000100,
        ST_WR_SP_LO   = 10'b0000001000,
        ST_WR_SP_HI   = 10'b0000010000,
        ST_WR_IL_HI   = 10'b0000100000,
        ST_WR_MODE    = 10'b0001000000,
        ST_WR_CMD     = 10'b0010000000,
        ST_STREAM     = 10'b0100000000,
        ST_RUN        = 10'b1000000000
    } t_seq_state;

    t_seq_state  r_state, n_state;
    logic [6:0]  r_wait, n_wait;
    logic [1:0]  r_fill, n_fill;
    logic        r_ready, n_ready;
    logic [15:0] r_reading, n_reading;
    logic [1:0]  r_count, n_count;
    logic [7:0]  r_frame [3];

    logic        store_we;
    logic [7:0]  tag;
    logic        tag_match;
    llfd_pkg::t_job_kind job_kind;
    logic [7:0]  job_addr;
    logic [7:0]  job_val;
    logic        job_push;

    assign tag = i_data_byte & llfd_pkg::TAG_MASK;
    assign tag_match = ((r_frame[0] & llfd_pkg::TAG_MASK) == tag) &&
                       ((r_frame[1] & llfd_pkg::TAG_MASK) == tag) &&
                       ((r_frame[2] & llfd_pkg::TAG_MASK) == tag);

    // Decode one transaction into state updates and at most one job
    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        n_fill    = r_fill;
        n_ready   = r_ready;
        n_reading = r_reading;
        n_count   = r_count;
        store_we  = 1'b0;
        job_push  = 1'b0;
        job_kind  = llfd_pkg::JOB_TRIGGER;
        job_addr  = 8'h00;
        job_val   = 8'h00;
        if (i_accept) begin
            case (i_opcode)
                llfd_pkg::OP_RESTART: begin
                    n_state  = ST_WAIT_FIRST;
                    n_wait   = 7'd0;
                    n_fill   = 2'd0;
                    job_push = 1'b1;
                    job_kind = llfd_pkg::JOB_WRITE;
                    job_addr = i_cfg.baud_addr;
                    job_val  = llfd_pkg::BAUD_VALUE;
                end
                llfd_pkg::OP_TICK: begin
                    if (r_state == ST_WAIT_FIRST) begin
                        if (r_wait >= i_cfg.first_wait) begin
                            job_push = 1'b1;
                            job_kind = llfd_pkg::JOB_BAUD;
                            n_wait   = 7'd0;
                            n_state  = ST_WAIT_BAUD;
                        end else begin
                            n_wait = r_wait + 7'd1;
                        end
                    end else if (r_state == ST_WAIT_BAUD) begin
                        if (r_wait >= i_cfg.baud_wait) begin
                            job_push = 1'b1;
                            job_kind = llfd_pkg::JOB_WRITE;
                            job_addr = i_cfg.il_lo_addr;
                            job_val  = llfd_pkg::IL_LO_VALUE;
                            n_state  = ST_WR_SP_LO;
                        end else begin
                            n_wait = r_wait + 7'd1;
                        end
                    end
                end
                llfd_pkg::OP_TX_DONE: begin
                    case (r_state)
                        ST_WR_SP_LO: begin
                            job_push = 1'b1;
                            job_kind = llfd_pkg::JOB_WRITE;
                            job_addr = i_cfg.sp_lo_addr;
                            job_val  = llfd_pkg::SP_LO_VALUE;
                            n_state  = ST_WR_SP_HI;
                        end
                        ST_WR_SP_HI: begin
                            job_push = 1'b1;
                            job_kind = llfd_pkg::JOB_WRITE;
                            job_addr = i_cfg.sp_hi_addr;
                            job_val  = llfd_pkg::SP_HI_VALUE;
                            n_state  = ST_WR_IL_HI;
                        end
                        ST_WR_IL_HI: begin
                            job_push = 1'b1;
                            job_kind = llfd_pkg::JOB_WRITE;
                            job_addr = i_cfg.il_hi_addr;
                            job_val  = llfd_pkg::IL_HI_VALUE;
                            n_state  = ST_WR_MODE;
                        end
                        ST_WR_MODE: begin
                            job_push = 1'b1;
                            job_kind = llfd_pkg::JOB_WRITE;
                            job_addr = i_cfg.mode_addr;
                            job_val  = llfd_pkg::MODE_VALUE;
                            n_state  = ST_WR_CMD;
                        end
                        ST_WR_CMD: begin
                            job_push = 1'b1;
                            job_kind = llfd_pkg::JOB_CMD;
                            n_state  = ST_STREAM;
                        end
                        ST_STREAM: begin
                            n_fill  = 2'd0;
                            n_state = ST_RUN;
                        end
                        default: ;
                    endcase
                end
                llfd_pkg::OP_RX_BYTE: begin
                    if (r_state == ST_RUN) begin
                        if (r_fill != 2'd3) begin
                            store_we = 1'b1;
                            n_fill   = r_fill + 2'd1;
                        end else begin
                            n_fill = 2'd0;
                            if (tag_match) begin
                                n_reading = {i_data_byte[3:0], r_frame[2][3:0],
                                             r_frame[1][3:0], r_frame[0][3:0]};
                                n_count   = tag[5:4];
                                n_ready   = 1'b1;
                                job_push  = 1'b1;
                                job_kind  = llfd_pkg::JOB_READING;
                            end
                        end
                    end
                end
                llfd_pkg::OP_TRIGGER: begin
                    n_ready  = 1'b0;
                    n_fill   = 2'd0;
                    job_push = 1'b1;
                    job_kind = llfd_pkg::JOB_TRIGGER;
                end
                default: ;
            endcase
        end
    end

    // Job carries the held values as they stand after this transaction
    assign o_job_push    = job_push;
    assign o_job.kind    = job_kind;
    assign o_job.addr    = job_addr;
    assign o_job.val     = job_val;
    assign o_job.reading = n_reading;
    assign o_job.count   = n_count;
    assign o_job.ready   = n_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wait    <= 7'd0;
            r_fill    <= 2'd0;
            r_ready   <= 1'b0;
            r_reading <= 16'h0000;
            r_count   <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_wait    <= n_wait;
            r_fill    <= n_fill;
            r_ready   <= n_ready;
            r_reading <= n_reading;
            r_count   <= n_count;
        end
    end

    // Partial frame bytes
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_frame[r_fill] <= i_data_byte;
        end
    end

    a_trigger_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_opcode == llfd_pkg::OP_TRIGGER) |=> (!r_ready && r_fill == 2'd0))
        else $error("trigger did not clear ready and partial frame");

    a_reading_job_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_push && job_kind == llfd_pkg::JOB_READING) |=> r_ready)
        else $error("decoded frame left ready low");

endmodule

// ----- rtl/core/llfd_jobq.sv -----
`timescale 1ns / 1ps
// Short job queue between front end and back end.
module llfd_jobq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  llfd_pkg::t_job      i_job,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output llfd_pkg::t_job      o_job
);

    llfd_pkg::t_job                 r_mem [llfd_pkg::JobDepth];
    logic [llfd_pkg::JobPtrW-1:0]   r_wr_ptr;
    logic [llfd_pkg::JobPtrW-1:0]   r_rd_ptr;
    logic [llfd_pkg::JobPtrW:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == (llfd_pkg::JobPtrW+1)'(llfd_pkg::JobDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (llfd_pkg::JobPtrW+1)'(llfd_pkg::JobDepth))
        else $error("job queue overfilled");

    a_push_to_empty_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && o_empty) |=> !o_empty)
        else $error("job pushed into empty queue was lost");

endmodule

// ----- rtl/core/llfd_back.sv -----
`timescale 1ns / 1ps
// Back end: expands queued jobs into result transactions through an output register.
module llfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  llfd_pkg::t_job      i_q_job,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [1:0]          o_result_kind,
    output logic [7:0]          o_tx_byte,
    output logic                o_last_of_run,
    output logic [15:0]         o_distance_reading,
    output logic [1:0]          o_frame_count,
    output logic                o_reading_ready
);

    llfd_pkg::t_job r_job;
    logic           r_job_valid;
    logic [2:0]     r_idx;
    logic           r_out_valid;
    logic [1:0]     r_out_kind;
    logic [7:0]     r_out_byte;
    logic           r_out_last;
    logic [15:0]    r_out_reading;
    logic [1:0]     r_out_count;
    logic           r_out_ready;

    logic           out_free;
    logic           emit;
    logic           at_last;
    logic           load;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = out_free && r_job_valid;
    assign at_last  = (r_idx == llfd_pkg::job_last_idx(r_job.kind));
    assign load     = !i_q_empty && (!r_job_valid || (emit && at_last));
    assign o_q_pop  = load;

    // Current job and position within it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else if (load) begin
            r_job_valid <= 1'b1;
            r_idx       <= 3'd0;
        end else if (emit) begin
            if (at_last) begin
                r_job_valid <= 1'b0;
                r_idx       <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind    <= llfd_pkg::job_result_kind(r_job.kind);
            r_out_byte    <= llfd_pkg::job_tx_byte(r_job.kind, r_job.addr, r_job.val, r_idx);
            r_out_last    <= at_last;
            r_out_reading <= r_job.reading;
            r_out_count   <= r_job.count;
            r_out_ready   <= r_job.ready;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_result_kind      = r_out_kind;
    assign o_tx_byte          = r_out_byte;
    assign o_last_of_run      = r_out_last;
    assign o_distance_reading = r_out_reading;
    assign o_frame_count      = r_out_count;
    assign o_reading_ready    = r_out_ready;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx <= llfd_pkg::job_last_idx(r_job.kind)))
        else $error("result index ran past end of job");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && !(emit && at_last)) |-> !o_q_pop)
        else $error("job taken from queue while current job unfinished");

endmodule

// ----- rtl/core/laser_link_setup_and_frame_decode_core.sv -----
`timescale 1ns / 1ps
// Top level: configuration registers, front end, job queue and back end.
//
//  Channel   Handshake                 Payload
//  input     push / full               i_opcode, i_data_byte
//  result    empty / pop               o_result_kind, o_tx_byte, o_last_of_run,
//                                      o_distance_reading, o_frame_count, o_reading_ready
//  config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  The front end takes one input transaction per cycle while full is low and queues
//  at most one job for it. The back end turns a job into 1, 2 or 6 results, one per
//  cycle while the receiver pops; a 4-entry job queue decouples the two sides. A job
//  passes the job queue, the current-job register and the output register; full rises
//  when 4 jobs wait. Reset is synchronous, active low; no clearing pass is needed after it.
module laser_link_setup_and_frame_decode_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_run,
    output logic [15:0] o_distance_reading,
    output logic [1:0]  o_frame_count,
    output logic        o_reading_ready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    llfd_pkg::t_cfg r_cfg;
    llfd_pkg::t_job front_job;
    llfd_pkg::t_job q_job;
    logic           front_push;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           in_accept;

    assign in_accept = push && !q_full;
    assign full      = q_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baud_addr  <= 8'd0;
            r_cfg.il_lo_addr <= 8'd0;
            r_cfg.il_hi_addr <= 8'd0;
            r_cfg.sp_lo_addr <= 8'd0;
            r_cfg.sp_hi_addr <= 8'd0;
            r_cfg.mode_addr  <= 8'd0;
            r_cfg.first_wait <= 7'd10;
            r_cfg.baud_wait  <= 7'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                llfd_pkg::CFG_BAUD_ADDR:  r_cfg.baud_addr  <= i_cfg_data;
                llfd_pkg::CFG_IL_LO_ADDR: r_cfg.il_lo_addr <= i_cfg_data;
                llfd_pkg::CFG_IL_HI_ADDR: r_cfg.il_hi_addr <= i_cfg_data;
                llfd_pkg::CFG_SP_LO_ADDR: r_cfg.sp_lo_addr <= i_cfg_data;
                llfd_pkg::CFG_SP_HI_ADDR: r_cfg.sp_hi_addr <= i_cfg_data;
                llfd_pkg::CFG_MODE_ADDR:  r_cfg.mode_addr  <= i_cfg_data;
                llfd_pkg::CFG_FIRST_WAIT: r_cfg.first_wait <= i_cfg_data[6:0];
                llfd_pkg::CFG_BAUD_WAIT:  r_cfg.baud_wait  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    llfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_job_push  (front_push),
        .o_job       (front_job)
    );

    llfd_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    llfd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_q_job            (q_job),
        .o_q_pop            (q_pop),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_result_kind      (o_result_kind),
        .o_tx_byte          (o_tx_byte),
        .o_last_of_run      (o_last_of_run),
        .o_distance_reading (o_distance_reading),
        .o_frame_count      (o_frame_count),
        .o_reading_ready    (o_reading_ready)
    );

endmodule

// ----- tb/link_decode_checker.sv -----
`timescale 1ns / 1ps
// Checker for the laser link core: tracks the sequence, predicts every result and compares.
module link_decode_checker
    import llfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  o_result_kind,
    input  logic [7:0]  o_tx_byte,
    input  logic        o_last_of_run,
    input  logic [15:0] o_distance_reading,
    input  logic [1:0]  o_frame_count,
    input  logic        o_reading_ready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output int          error_count,
    output int          results_outstanding
);

    // Setup sequence as seen from the link side
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_WAIT_FIRST,
        SEQ_WAIT_BAUD,
        SEQ_WR_SP_LO,
        SEQ_WR_SP_HI,
        SEQ_WR_IL_HI,
        SEQ_WR_MODE,
        SEQ_WR_CMD,
        SEQ_STREAM,
        SEQ_RUN
    } t_link_seq;

    typedef struct packed {
        t_result_kind kind;
        logic [7:0]   tx;
        logic         last;
        logic [15:0]  distance;
        logic [1:0]   cnt;
        logic         rdy;
    } t_link_result;

    t_link_result pending_link_results [$];
    t_link_result item_results [$];

    // Predicted link state
    t_link_seq   link_seq;
    logic [6:0]  tick_count;
    logic [7:0]  frame_bytes [3];
    logic [1:0]  frame_fill;
    logic        ready_q;
    logic [15:0] reading_q;
    logic [1:0]  count_q;

    // Shadow of the register file
    logic [7:0]  baud_addr, il_lo_addr, il_hi_addr, sp_lo_addr, sp_hi_addr, mode_addr;
    logic [6:0]  first_wait, baud_wait;

    int errors_seen = 0;
    assign error_count = errors_seen;

    function automatic void reset_link_model();
        baud_addr  = '0;
        il_lo_addr = '0;
        il_hi_addr = '0;
        sp_lo_addr = '0;
        sp_hi_addr = '0;
        mode_addr  = '0;
        first_wait = 7'd10;
        baud_wait  = 7'd100;
        link_seq   = SEQ_IDLE;
        tick_count = '0;
        frame_fill = '0;
        ready_q    = 1'b0;
        reading_q  = '0;
        count_q    = '0;
        pending_link_results.delete();
    endfunction

    function automatic void stage_result(input t_result_kind kind, input logic [7:0] tx);
        t_link_result r;
        r = '0;
        r.kind = kind;
        r.tx = tx;
        item_results.push_back(r);
    endfunction

    // Six-byte register write: header, address nibbles, value nibbles
    function automatic void stage_reg_write(input logic [7:0] addr, input logic [7:0] val);
        stage_result(RK_TX_BYTE, WR_HEAD0);
        stage_result(RK_TX_BYTE, WR_HEAD1);
        stage_result(RK_TX_BYTE, NIB_FLAG | {4'h0, addr[3:0]});
        stage_result(RK_TX_BYTE, NIB_FLAG | {4'h0, addr[7:4]});
        stage_result(RK_TX_BYTE, NIB_FLAG | {4'h0, val[3:0]});
        stage_result(RK_TX_BYTE, NIB_FLAG | {4'h0, val[7:4]});
    endfunction

    // A wait of limit L ends on the (L+1)-th tick
    function automatic bit wait_over(input logic [6:0] limit);
        if (tick_count >= limit)
            return 1'b1;
        tick_count = tick_count + 7'd1;
        return 1'b0;
    endfunction

    function automatic void take_rx_byte(input logic [7:0] b);
        logic [7:0] tag;
        if (frame_fill < 2'd3) begin
            frame_bytes[frame_fill] = b;
            frame_fill = frame_fill + 2'd1;
            return;
        end
        frame_fill = '0;
        tag = b & TAG_MASK;
        if ((frame_bytes[0] & TAG_MASK) == tag && (frame_bytes[1] & TAG_MASK) == tag &&
            (frame_bytes[2] & TAG_MASK) == tag) begin
            reading_q = {b[3:0], frame_bytes[2][3:0], frame_bytes[1][3:0], frame_bytes[0][3:0]};
            count_q = tag[5:4];
            ready_q = 1'b1;
            stage_result(RK_READING, 8'h00);
        end
    endfunction

    function automatic void predict_link_results(input logic [2:0] op, input logic [7:0] db);
        t_link_result r;
        item_results.delete();
        case (op)
            OP_RESTART: begin
                link_seq = SEQ_WAIT_FIRST;
                tick_count = '0;
                frame_fill = '0;
                stage_reg_write(baud_addr, BAUD_VALUE);
            end
            OP_TICK: begin
                if (link_seq == SEQ_WAIT_FIRST) begin
                    if (wait_over(first_wait)) begin
                        stage_result(RK_BAUD, 8'h00);
                        tick_count = '0;
                        link_seq = SEQ_WAIT_BAUD;
                    end
                end else if (link_seq == SEQ_WAIT_BAUD) begin
                    if (wait_over(baud_wait)) begin
                        stage_reg_write(il_lo_addr, IL_LO_VALUE);
                        link_seq = SEQ_WR_SP_LO;
                    end
                end
            end
            OP_TX_DONE: begin
                case (link_seq)
                    SEQ_WR_SP_LO: begin
                        stage_reg_write(sp_lo_addr, SP_LO_VALUE);
                        link_seq = SEQ_WR_SP_HI;
                    end
                    SEQ_WR_SP_HI: begin
                        stage_reg_write(sp_hi_addr, SP_HI_VALUE);
                        link_seq = SEQ_WR_IL_HI;
                    end
                    SEQ_WR_IL_HI: begin
                        stage_reg_write(il_hi_addr, IL_HI_VALUE);
                        link_seq = SEQ_WR_MODE;
                    end
                    SEQ_WR_MODE: begin
                        stage_reg_write(mode_addr, MODE_VALUE);
                        link_seq = SEQ_WR_CMD;
                    end
                    SEQ_WR_CMD: begin
                        stage_result(RK_TX_BYTE, STREAM_BYTE0);
                        stage_result(RK_TX_BYTE, STREAM_BYTE1);
                        link_seq = SEQ_STREAM;
                    end
                    SEQ_STREAM: begin
                        frame_fill = '0;
                        link_seq = SEQ_RUN;
                    end
                    default: ;
                endcase
            end
            OP_RX_BYTE: begin
                if (link_seq == SEQ_RUN)
                    take_rx_byte(db);
            end
            OP_TRIGGER: begin
                ready_q = 1'b0;
                frame_fill = '0;
                stage_result(RK_TRIGGER, 8'h00);
            end
            default: ;
        endcase
        // Every result carries the held reading after this transaction
        for (int k = 0; k < item_results.size(); k++) begin
            r = item_results[k];
            r.distance = reading_q;
            r.cnt = count_q;
            r.rdy = ready_q;
            r.last = (k == item_results.size() - 1);
            pending_link_results.push_back(r);
        end
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors_seen++;
        end
    endtask

    // Sample all channels on the same edge the core does
    always @(posedge i_clk) begin : monitor
        t_link_result want;
        if (!i_rst_n) begin
            reset_link_model();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BAUD_ADDR:  baud_addr  = i_cfg_data;
                    CFG_IL_LO_ADDR: il_lo_addr = i_cfg_data;
                    CFG_IL_HI_ADDR: il_hi_addr = i_cfg_data;
                    CFG_SP_LO_ADDR: sp_lo_addr = i_cfg_data;
                    CFG_SP_HI_ADDR: sp_hi_addr = i_cfg_data;
                    CFG_MODE_ADDR:  mode_addr  = i_cfg_data;
                    CFG_FIRST_WAIT: first_wait = i_cfg_data[6:0];
                    CFG_BAUD_WAIT:  baud_wait  = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            // Result transaction
            if (pop && !empty) begin
                if (pending_link_results.size() == 0) begin
                    $display("%0t: result with none expected, kind %0h tx_byte %0h",
                             $time, o_result_kind, o_tx_byte);
                    errors_seen++;
                end else begin
                    want = pending_link_results.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("tx_byte", want.tx, o_tx_byte);
                    check_field("last_of_run", want.last, o_last_of_run);
                    check_field("distance_reading", want.distance, o_distance_reading);
                    check_field("frame_count", want.cnt, o_frame_count);
                    check_field("reading_ready", want.rdy, o_reading_ready);
                end
            end
            // Input transaction
            if (push && !full)
                predict_link_results(i_opcode, i_data_byte);
        end
        results_outstanding <= pending_link_results.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the laser link setup and decode core.
module testbench;
    import llfd_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int ItemGoal       = 300;
    localparam int LongHoldCycles = 80;
    localparam int SettleCycles   = 8;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_opcode = OP_RESTART;
    logic [7:0]  i_data_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last_of_run;
    logic [15:0] o_distance_reading;
    logic [1:0]  o_frame_count;
    logic        o_reading_ready;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CFG_BAUD_ADDR;
    logic [7:0]  i_cfg_data = '0;

    int error_count;
    int results_outstanding;
    int items_sent = 0;
    int burst_left = 0;
    int long_holds_asked = 0;
    int long_holds_done = 0;
    logic [6:0] first_wait_set = 7'd10;
    logic [6:0] baud_wait_set = 7'd100;

    laser_link_setup_and_frame_decode_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_opcode           (i_opcode),
        .i_data_byte        (i_data_byte),
        .empty              (empty),
        .pop                (pop),
        .o_result_kind      (o_result_kind),
        .o_tx_byte          (o_tx_byte),
        .o_last_of_run      (o_last_of_run),
        .o_distance_reading (o_distance_reading),
        .o_frame_count      (o_frame_count),
        .o_reading_ready    (o_reading_ready),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    link_decode_checker link_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_opcode           (i_opcode),
        .i_data_byte        (i_data_byte),
        .empty              (empty),
        .pop                (pop),
        .o_result_kind      (o_result_kind),
        .o_tx_byte          (o_tx_byte),
        .o_last_of_run      (o_last_of_run),
        .o_distance_reading (o_distance_reading),
        .o_frame_count      (o_frame_count),
        .o_reading_ready    (o_reading_ready),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .error_count        (error_count),
        .results_outstanding(results_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One input transaction; bursts of random length with random gaps between them
    task automatic send_item(input logic [2:0] op, input logic [7:0] db);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        push <= 1'b1;
        i_opcode <= op;
        i_data_byte <= db;
        do @(posedge i_clk); while (full);
        burst_left--;
        items_sent++;
    endtask

    // Stop sending and let every expected result drain out
    task automatic wait_for_quiet();
        push <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (results_outstanding != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Register i of addrs sits at bits 8*i +: 8; only called with the core idle
    task automatic program_registers(input logic [47:0] addrs, input logic [7:0] fw,
                                     input logic [7:0] bw);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= addrs[8*i +: 8];
            @(posedge i_clk);
        end
        i_cfg_idx <= CFG_FIRST_WAIT;
        i_cfg_data <= fw;
        @(posedge i_clk);
        i_cfg_idx <= CFG_BAUD_WAIT;
        i_cfg_data <= bw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        first_wait_set = fw[6:0];
        baud_wait_set = bw[6:0];
    endtask

    // Occasional stray transaction: trigger, spare opcode or one the current stage ignores
    task automatic maybe_noise(input logic [2:0] ignored_op);
        int pick;
        if ($urandom_range(0, 11) != 0)
            return;
        pick = $urandom_range(0, 3);
        case (pick)
            0:       send_item(OP_TRIGGER, 8'($urandom_range(0, 255)));
            1:       send_item(ignored_op, 8'($urandom_range(0, 255)));
            default: send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                               8'($urandom_range(0, 255)));
        endcase
    endtask

    // Full bring-up followed by a run of frames
    task automatic run_session(input int n_frames, input bit long_hold, input bit pause_mid);
        int bad_pos;
        logic [1:0] tag;
        logic [7:0] b;
        send_item(OP_RESTART, 8'($urandom_range(0, 255)));
        // receiver holds off while the setup writes pile up
        if (long_hold)
            long_holds_asked <= long_holds_asked + 1;
        for (int k = 0; k <= first_wait_set; k++) begin
            maybe_noise(OP_TX_DONE);
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
        end
        for (int k = 0; k <= baud_wait_set; k++) begin
            maybe_noise(OP_RX_BYTE);
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
        end
        for (int k = 0; k < 6; k++) begin
            maybe_noise(OP_TICK);
            send_item(OP_TX_DONE, 8'($urandom_range(0, 255)));
        end
        if (pause_mid)
            wait_for_quiet();
        for (int j = 0; j < n_frames; j++) begin
            tag = 2'($urandom_range(0, 3));
            bad_pos = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 4;
            for (int k = 0; k < 4; k++) begin
                maybe_noise($urandom_range(0, 1) ? OP_TICK : OP_TX_DONE);
                b = 8'($urandom_range(0, 255));
                b[5:4] = (k == bad_pos) ? 2'(tag + $urandom_range(1, 3)) : tag;
                send_item(OP_RX_BYTE, b);
            end
        end
    endtask

    // Receiver: stall patterns of its own, plus long hold-offs on request
    initial begin : result_sink
        logic [7:0] mask;
        int stretch;
        mask = 8'hff;
        stretch = 0;
        forever begin
            @(posedge i_clk);
            if (long_holds_done != long_holds_asked) begin
                pop <= 1'b0;
                repeat (LongHoldCycles) @(posedge i_clk);
                long_holds_done++;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(16, 64);
                    case ($urandom_range(0, 3))
                        0:       mask = 8'hff;
                        1:       mask = 8'h11;
                        default: mask = 8'($urandom_range(1, 255));
                    endcase
                end
                pop <= mask[0];
                mask = {mask[0], mask[7:1]};
                stretch--;
            end
        end
    end

    initial begin : stimulus
        int session;
        session = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme addresses, first wait 0, baud wait 1
        program_registers({8'hc3, 8'h3c, 8'h5a, 8'ha5, 8'h00, 8'hff}, 8'h00, 8'h01);
        // idle core ignores everything but trigger and restart
        send_item(OP_TICK, 8'h00);
        send_item(OP_RX_BYTE, 8'h00);
        send_item(OP_SPARE_LAST, 8'hff);
        send_item(OP_TRIGGER, 8'h00);
        send_item(OP_RESTART, 8'h00);
        // out-of-place transmit-done and a byte during setup
        send_item(OP_TX_DONE, 8'h00);
        send_item(OP_RX_BYTE, 8'hff);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        for (int k = 0; k < 6; k++)
            send_item(OP_TX_DONE, 8'h00);
        // all-ones frame, then a trigger dropping a partial frame, then a mismatched frame
        for (int k = 0; k < 4; k++)
            send_item(OP_RX_BYTE, 8'hff);
        send_item(OP_RX_BYTE, 8'h12);
        send_item(OP_RX_BYTE, 8'h23);
        send_item(OP_TRIGGER, 8'h00);
        send_item(OP_RX_BYTE, 8'h05);
        send_item(OP_RX_BYTE, 8'h15);
        send_item(OP_RX_BYTE, 8'h25);
        send_item(OP_RX_BYTE, 8'h35);

        // Random sessions, reconfigured every few
        while (items_sent < ItemGoal) begin
            if (session % 3 == 0) begin
                wait_for_quiet();
                if (session == 3)
                    program_registers({16'($urandom), 32'($urandom)}, 8'hff, 8'h83);
                else
                    program_registers({16'($urandom), 32'($urandom)},
                                      {1'($urandom_range(0, 1)), 7'($urandom_range(0, 3))},
                                      {1'($urandom_range(0, 1)), 7'($urandom_range(0, 3))});
            end
            run_session($urandom_range(3, 12), session % 4 == 1, session % 4 == 2);
            if (session % 5 == 4) begin
                for (int k = 0; k < 12; k++)
                    send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            session++;
        end

        wait_for_quiet();
        repeat (2 * SettleCycles) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
